// ----- rtl/tqm_pkg.sv -----
// Shared types and constants for the traffic quota meter.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package tqm_pkg;

    // Stream payload widths
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 72;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Opcodes carried in the input tuser
    localparam logic [1:0] OP_UPDATE = 2'd0;
    localparam logic [1:0] OP_END    = 2'd1;
    localparam logic [1:0] OP_START  = 2'd2;

    // Status codes
    localparam logic [1:0] ST_DISABLED = 2'd0;
    localparam logic [1:0] ST_BELOW    = 2'd1;
    localparam logic [1:0] ST_BETWEEN  = 2'd2;
    localparam logic [1:0] ST_OVER     = 2'd3;

    // Warning codes
    localparam logic [1:0] WARN_NONE    = 2'd0;
    localparam logic [1:0] WARN_TIME    = 2'd1;
    localparam logic [1:0] WARN_TRAFFIC = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOME_DATA   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROAM_DATA   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HOME_TIME   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROAM_TIME   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WARN_ENABLE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ROAM_MODE   = 3'd6;

    localparam logic [6:0] THRESHOLD_RESET = 7'd80;

    // Largest total whose product with 100 still fits in 64 bits
    localparam logic [63:0] TOTAL_SCALE_MAX = 64'd184467440737095516;

    typedef struct packed {
        logic [6:0]  threshold_percent;
        logic [19:0] home_data_limit_mib;
        logic [19:0] roaming_data_limit_mib;
        logic [31:0] home_time_limit_s;
        logic [31:0] roaming_time_limit_s;
        logic        warn_enable;
        logic        roaming_mode;
    } t_cfg;

    // Controller to datapath commands, at most one high per cycle
    typedef struct packed {
        logic accept;   // capture input item
        logic apply;    // update counters and totals
        logic total;    // form total and threshold products
        logic scale;    // scale total by 100
        logic status;   // statuses and warning
        logic load;     // move result into output register
    } t_dp_cmd;

endpackage

`default_nettype wire

// ----- rtl/tqm_cfg_regs.sv -----
// Configuration register file of the traffic quota meter.
// Depends on tqm_pkg for the register layout and indexes.
`timescale 1ns / 1ps
`default_nettype none

module tqm_cfg_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_wr_en,
    input  wire logic [tqm_pkg::CFG_IDX_W-1:0]  i_wr_index,
    input  wire logic [tqm_pkg::CFG_DATA_W-1:0] i_wr_data,
    output tqm_pkg::t_cfg                       o_cfg
);
    import tqm_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Write decode
    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            unique case (i_wr_index)
                CFG_THRESHOLD:   n_cfg.threshold_percent      = i_wr_data[6:0];
                CFG_HOME_DATA:   n_cfg.home_data_limit_mib    = i_wr_data[19:0];
                CFG_ROAM_DATA:   n_cfg.roaming_data_limit_mib = i_wr_data[19:0];
                CFG_HOME_TIME:   n_cfg.home_time_limit_s      = i_wr_data;
                CFG_ROAM_TIME:   n_cfg.roaming_time_limit_s   = i_wr_data;
                CFG_WARN_ENABLE: n_cfg.warn_enable            = i_wr_data[0];
                CFG_ROAM_MODE:   n_cfg.roaming_mode           = i_wr_data[0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold_percent      <= THRESHOLD_RESET;
            r_cfg.home_data_limit_mib    <= '0;
            r_cfg.roaming_data_limit_mib <= '0;
            r_cfg.home_time_limit_s      <= '0;
            r_cfg.roaming_time_limit_s   <= '0;
            r_cfg.warn_enable            <= 1'b1;
            r_cfg.roaming_mode           <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ----- rtl/tqm_ctrl.sv -----
// Sequencing controller of the traffic quota meter.
// Depends on tqm_pkg for the datapath command struct.
`timescale 1ns / 1ps
`default_nettype none

module tqm_ctrl (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output tqm_pkg::t_dp_cmd o_cmd
);
    import tqm_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_APPLY  = 6'b000010,
        S_TOTAL  = 6'b000100,
        S_SCALE  = 6'b001000,
        S_STATUS = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_m_valid;
    logic   n_m_valid;
    logic   w_accept;
    logic   w_load;

    assign w_accept = (r_state == S_IDLE) && i_s_tvalid;
    // Result may enter the output register once it is empty or being drained
    assign w_load   = (r_state == S_DONE) && (!r_m_valid || i_m_tready);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_s_tvalid) n_state = S_APPLY;
            S_APPLY:  n_state = S_TOTAL;
            S_TOTAL:  n_state = S_SCALE;
            S_SCALE:  n_state = S_STATUS;
            S_STATUS: n_state = S_DONE;
            S_DONE:   if (w_load) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Output valid flag
    always_comb begin
        n_m_valid = r_m_valid;
        if (w_load) begin
            n_m_valid = 1'b1;
        end else if (r_m_valid && i_m_tready) begin
            n_m_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

    // Commands
    always_comb begin
        o_cmd        = '0;
        o_cmd.accept = w_accept;
        o_cmd.apply  = (r_state == S_APPLY);
        o_cmd.total  = (r_state == S_TOTAL);
        o_cmd.scale  = (r_state == S_SCALE);
        o_cmd.status = (r_state == S_STATUS);
        o_cmd.load   = w_load;
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_valid;

endmodule

`default_nettype wire

// ----- rtl/tqm_datapath.sv -----
// Datapath of the traffic quota meter: counters, totals, status compares
// and the output register. Depends on tqm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tqm_datapath (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire tqm_pkg::t_cfg                  i_cfg,
    input  wire tqm_pkg::t_dp_cmd               i_cmd,
    input  wire logic [1:0]                     i_opcode,
    input  wire logic [tqm_pkg::IN_DATA_W-1:0]  i_data,
    output logic      [tqm_pkg::OUT_DATA_W-1:0] o_data
);
    import tqm_pkg::*;

    // Captured item
    logic [1:0]  r_op;
    logic [31:0] r_sent;
    logic [31:0] r_rcvd;
    logic [31:0] r_secs;

    // Metering state
    logic [63:0] r_home_bytes, n_home_bytes;
    logic [63:0] r_roam_bytes, n_roam_bytes;
    logic [31:0] r_home_secs,  n_home_secs;
    logic [31:0] r_roam_secs,  n_roam_secs;
    logic [31:0] r_last_sent,  n_last_sent;
    logic [31:0] r_last_rcvd,  n_last_rcvd;
    logic        r_timing_valid, n_timing_valid;
    logic        r_warn_armed;
    logic        r_creset;

    // Intermediate results
    logic [63:0] r_total;
    logic [38:0] r_secs100;
    logic [38:0] r_th_tlim;
    logic [26:0] r_th_dlim;
    logic [63:0] r_total100;
    logic        r_big;
    logic [1:0]  r_traffic_st;
    logic [1:0]  r_time_st;
    logic [1:0]  r_warn;
    logic [OUT_DATA_W-1:0] r_out;

    // Apply stage signals
    logic        w_decrease;
    logic        w_fold;
    logic [31:0] w_adj_sent;
    logic [31:0] w_adj_rcvd;
    logic [32:0] w_cnt;
    logic [63:0] w_base_bytes;
    logic [31:0] w_base_secs;
    logic [64:0] w_bytes_sum;
    logic [32:0] w_secs_sum;
    logic [63:0] w_bytes_fold;
    logic [31:0] w_secs_fold;

    // Mode selections and later stage signals
    logic [19:0] w_dlim;
    logic [31:0] w_tlim;
    logic [31:0] w_secs_sel;
    logic [64:0] w_total_sum;
    logic [63:0] w_total;
    logic [38:0] w_secs_ext;
    logic [63:0] w_total100;
    logic [63:0] w_dlim_bytes;
    logic [63:0] w_th_dlim_bytes;
    logic [1:0]  w_traffic_st;
    logic [1:0]  w_time_st;
    logic [1:0]  w_warn;

    assign w_dlim     = i_cfg.roaming_mode ? i_cfg.roaming_data_limit_mib
                                           : i_cfg.home_data_limit_mib;
    assign w_tlim     = i_cfg.roaming_mode ? i_cfg.roaming_time_limit_s
                                           : i_cfg.home_time_limit_s;
    assign w_secs_sel = i_cfg.roaming_mode ? r_roam_secs : r_home_secs;

    // Capture the item
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op   <= i_opcode;
            r_sent <= i_data[31:0];
            r_rcvd <= i_data[63:32];
            r_secs <= i_data[95:64];
        end
    end

    // Counter decrease check, fold sums
    assign w_decrease   = (r_sent < r_last_sent) || (r_rcvd < r_last_rcvd);
    assign w_adj_sent   = (r_sent > r_last_sent) ? (r_sent - r_last_sent) : r_sent;
    assign w_adj_rcvd   = (r_rcvd > r_last_rcvd) ? (r_rcvd - r_last_rcvd) : r_rcvd;
    assign w_fold       = ((r_op == OP_UPDATE) && w_decrease) || (r_op == OP_END);
    assign w_cnt        = {1'b0, r_last_sent} + {1'b0, r_last_rcvd};
    assign w_base_bytes = i_cfg.roaming_mode ? r_roam_bytes : r_home_bytes;
    assign w_base_secs  = i_cfg.roaming_mode ? r_roam_secs : r_home_secs;
    assign w_bytes_sum  = {1'b0, w_base_bytes} + {32'b0, w_cnt};
    assign w_secs_sum   = {1'b0, w_base_secs} + {1'b0, r_secs};
    assign w_bytes_fold = w_bytes_sum[64] ? '1 : w_bytes_sum[63:0];
    // Seconds only move while the session is timed
    assign w_secs_fold  = !r_timing_valid ? w_base_secs
                        : (w_secs_sum[32] ? '1 : w_secs_sum[31:0]);

    // Next metering state on the apply step
    always_comb begin
        n_home_bytes   = r_home_bytes;
        n_roam_bytes   = r_roam_bytes;
        n_home_secs    = r_home_secs;
        n_roam_secs    = r_roam_secs;
        n_last_sent    = r_last_sent;
        n_last_rcvd    = r_last_rcvd;
        n_timing_valid = r_timing_valid;
        if (w_fold) begin
            if (i_cfg.roaming_mode) begin
                n_roam_bytes = w_bytes_fold;
                n_roam_secs  = w_secs_fold;
            end else begin
                n_home_bytes = w_bytes_fold;
                n_home_secs  = w_secs_fold;
            end
            n_timing_valid = 1'b0;
            n_last_sent    = '0;
            n_last_rcvd    = '0;
        end
        if (r_op == OP_UPDATE) begin
            n_last_sent = w_decrease ? w_adj_sent : r_sent;
            n_last_rcvd = w_decrease ? w_adj_rcvd : r_rcvd;
        end
        if (r_op == OP_START) begin
            n_timing_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_home_bytes   <= '0;
            r_roam_bytes   <= '0;
            r_home_secs    <= '0;
            r_roam_secs    <= '0;
            r_last_sent    <= '0;
            r_last_rcvd    <= '0;
            r_timing_valid <= 1'b0;
            r_warn_armed   <= 1'b1;
        end else begin
            if (i_cmd.apply) begin
                r_home_bytes   <= n_home_bytes;
                r_roam_bytes   <= n_roam_bytes;
                r_home_secs    <= n_home_secs;
                r_roam_secs    <= n_roam_secs;
                r_last_sent    <= n_last_sent;
                r_last_rcvd    <= n_last_rcvd;
                r_timing_valid <= n_timing_valid;
                if (r_op == OP_START) begin
                    r_warn_armed <= i_cfg.warn_enable;
                end
            end else if (i_cmd.status && (w_warn != WARN_NONE)) begin
                r_warn_armed <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            r_creset <= (r_op == OP_UPDATE) && w_decrease;
        end
    end

    // Total for the mode and threshold products
    assign w_total_sum = {1'b0, w_base_bytes}
                       + {32'b0, ({1'b0, r_last_sent} + {1'b0, r_last_rcvd})};
    assign w_total     = w_total_sum[64] ? '1 : w_total_sum[63:0];
    assign w_secs_ext  = {7'b0, w_secs_sel};

    always_ff @(posedge i_clk) begin
        if (i_cmd.total) begin
            r_total   <= w_total;
            // times 100 = 64 + 32 + 4
            r_secs100 <= (w_secs_ext << 6) + (w_secs_ext << 5) + (w_secs_ext << 2);
            r_th_tlim <= {32'b0, i_cfg.threshold_percent} * {7'b0, w_tlim};
            r_th_dlim <= {20'b0, i_cfg.threshold_percent} * {7'b0, w_dlim};
        end
    end

    // Scale the total by 100
    assign w_total100 = (r_total << 6) + (r_total << 5) + (r_total << 2);

    always_ff @(posedge i_clk) begin
        if (i_cmd.scale) begin
            r_total100 <= w_total100;
            r_big      <= (r_total > TOTAL_SCALE_MAX);
        end
    end

    // Status by comparing 100*usage against multiples of the limit:
    // pct is zero, below threshold, between threshold and 100, or at least 100
    assign w_dlim_bytes    = {24'b0, w_dlim, 20'b0};
    assign w_th_dlim_bytes = {17'b0, r_th_dlim, 20'b0};

    always_comb begin
        if (w_dlim == '0) begin
            w_traffic_st = ST_DISABLED;
        end else if (r_big) begin
            w_traffic_st = ST_OVER;
        end else if (r_total100 < w_dlim_bytes) begin
            w_traffic_st = ST_DISABLED;
        end else if (r_total100 < w_th_dlim_bytes) begin
            w_traffic_st = ST_BELOW;
        end else if (r_total >= w_dlim_bytes) begin
            w_traffic_st = ST_OVER;
        end else begin
            w_traffic_st = ST_BETWEEN;
        end
    end

    always_comb begin
        if (w_tlim == '0) begin
            w_time_st = ST_DISABLED;
        end else if (r_secs100 < {7'b0, w_tlim}) begin
            w_time_st = ST_DISABLED;
        end else if (r_secs100 < r_th_tlim) begin
            w_time_st = ST_BELOW;
        end else if (w_secs_sel >= w_tlim) begin
            w_time_st = ST_OVER;
        end else begin
            w_time_st = ST_BETWEEN;
        end
    end

    // One-shot warning, time first
    always_comb begin
        w_warn = WARN_NONE;
        if ((r_op == OP_UPDATE) && r_warn_armed) begin
            if ((w_time_st == ST_OVER) || (w_time_st == ST_BETWEEN)) begin
                w_warn = WARN_TIME;
            end else if ((w_traffic_st == ST_OVER) || (w_traffic_st == ST_BETWEEN)) begin
                w_warn = WARN_TRAFFIC;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.status) begin
            r_traffic_st <= w_traffic_st;
            r_time_st    <= w_time_st;
            r_warn       <= w_warn;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out <= {1'b0, r_creset, r_warn, r_time_st, r_traffic_st, r_total};
        end
    end

    assign o_data = r_out;

endmodule

`default_nettype wire

// ----- rtl/traffic_quota_meter.sv -----
// Top level of the traffic quota meter: stream ports, configuration port.
// Depends on tqm_pkg, tqm_cfg_regs, tqm_ctrl and tqm_datapath.
`timescale 1ns / 1ps
`default_nettype none

// Meters link usage against a home or roaming quota. Each input item is a
// counter update, session end or session start (opcode in tuser) and gives
// exactly one result item. From acceptance to its result entering the output
// register, an item passes one apply step, one step for the mode total and
// threshold products, one for the scale by 100, one for the status compares
// and warning, and the load. The controller works on one item at a time, so
// the input takes no new item until the result of the last one is loaded; a
// result waiting in the output register does not stop the next item from
// being accepted, only its load. Percent statuses are found by comparing
// 100*usage against the limit and threshold*limit, no divider.
// Configuration writes are taken in any cycle and must be issued while idle.
module traffic_quota_meter (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // Input items
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // [31:0] sent_count, [63:32] received_count, [95:64] session_seconds
    input  wire logic [tqm_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // [1:0] opcode
    input  wire logic [1:0]                     s_axis_tuser,
    // Result items
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [63:0] total_traffic, [65:64] traffic_status, [67:66] time_status,
    // [69:68] warning, [70] counter_reset, [71] zero
    output logic      [tqm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // Configuration writes
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [tqm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [tqm_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import tqm_pkg::*;

    t_cfg    w_cfg;
    t_dp_cmd w_cmd;

    assign o_cfg_ready = 1'b1;

    tqm_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    tqm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_cmd      (w_cmd)
    );

    tqm_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_cmd    (w_cmd),
        .i_opcode (s_axis_tuser),
        .i_data   (s_axis_tdata),
        .o_data   (m_axis_tdata)
    );

    // One item in flight: no acceptance right after an acceptance
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while an item is in flight");

    // A new result appears only by a load from the datapath
    a_load_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(w_cmd.load))
        else $error("output valid rose without a result load");

    // Warning never carries the unused code, and the pad bit stays clear
    a_warn_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((m_axis_tdata[69:68] != 2'b11) && !m_axis_tdata[71]))
        else $error("bad warning code or pad bit in result");

    // At most one datapath command per cycle
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_cmd))
        else $error("more than one datapath command in a cycle");

endmodule

`default_nettype wire
